// File: sv/fpre_pkg.sv
// Shared types and constants of the predictive Rice encoder.
package fpre_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WORD_BITS   = 32;
    localparam int TOTAL_BITS  = 16;
    localparam int NUM_COEF    = 4;
    localparam int MAX_SHIFT   = 16;
    localparam int ESC_Q       = 8;
    localparam int ESC_LEN     = ESC_Q + 1 + SAMPLE_BITS;
    localparam int CODE_BITS   = SAMPLE_BITS + 1;
    localparam int LEN_BITS    = 5;
    localparam int OUT_DEPTH   = 4;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_RICE_SHIFT = 3'd0,
        REG_TAP_COUNT  = 3'd1,
        REG_COEF_ZERO  = 3'd2,
        REG_COEF_ONE   = 3'd3,
        REG_COEF_TWO   = 3'd4,
        REG_COEF_THREE = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [4:0]                       rice_shift;
        logic [2:0]                       tap_count;
        logic [NUM_COEF-1:0][SAMPLE_BITS-1:0] coef;
    } cfg_t;

    // Rice code of one sample, right-aligned in len bits (leading zeros implied)
    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic [LEN_BITS-1:0]  len;
        logic                 last;
    } code_t;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] total;
        logic                  final_word;
        logic [WORD_BITS-1:0]  word;
    } result_t;

    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

// File: sv/fpre_filter.sv
// Prediction filter stage: sample history and one registered product per tap.
module fpre_filter #(
    parameter int MAX_TAPS = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fpre_pkg::cfg_t                    cfg,
    input  logic                              load,
    input  logic                              in_accept,
    input  logic [fpre_pkg::SAMPLE_BITS-1:0]  in_sample,
    input  logic                              in_last,
    output logic                              out_valid,
    output logic [fpre_pkg::SAMPLE_BITS-1:0]  out_prod [MAX_TAPS],
    output logic                              out_last
);
    localparam int HIST = MAX_TAPS - 1;
    localparam int SW   = $clog2(MAX_TAPS);

    logic [fpre_pkg::SAMPLE_BITS-1:0] hist_reg  [HIST];
    logic [fpre_pkg::SAMPLE_BITS-1:0] hist_next [HIST];
    logic [SW-1:0] seen_reg, seen_next;
    logic          valid_reg, valid_next;
    logic [fpre_pkg::SAMPLE_BITS-1:0] prod_reg  [MAX_TAPS];
    logic [fpre_pkg::SAMPLE_BITS-1:0] prod_next [MAX_TAPS];
    logic          last_reg;

    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_lane
        logic [fpre_pkg::SAMPLE_BITS-1:0] coef_j;
        logic [fpre_pkg::SAMPLE_BITS-1:0] tap_sample;
        logic                             lane_en;

        if (j < fpre_pkg::NUM_COEF) begin : g_coef
            assign coef_j = cfg.coef[j];
        end else begin : g_nocoef
            assign coef_j = '0;
        end

        if (j == 0) begin : g_cur
            assign tap_sample = in_sample;
            assign lane_en    = 1'b1;
        end else begin : g_hist
            assign tap_sample = hist_reg[j-1];
            // taps beyond tap_count or before the waveform start drop out
            assign lane_en    = (int'(cfg.tap_count) > j) && (int'(seen_reg) >= j);
        end

        // only the low 16 bits of each product matter after the wrap
        assign prod_next[j] = lane_en ? fpre_pkg::SAMPLE_BITS'(coef_j * tap_sample) : '0;
    end

    always_comb begin
        valid_next = load ? in_accept : valid_reg;
        hist_next  = hist_reg;
        seen_next  = seen_reg;
        if (in_accept) begin
            if (in_last) begin
                for (int i = 0; i < HIST; i++) begin
                    hist_next[i] = '0;
                end
                seen_next = '0;
            end else begin
                hist_next[0] = in_sample;
                for (int i = 1; i < HIST; i++) begin
                    hist_next[i] = hist_reg[i-1];
                end
                if (int'(seen_reg) < HIST) begin
                    seen_next = seen_reg + SW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            seen_reg  <= '0;
            for (int i = 0; i < HIST; i++) begin
                hist_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            seen_reg  <= seen_next;
            hist_reg  <= hist_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            prod_reg <= prod_next;
            last_reg <= in_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;
    assign out_last  = last_reg;

endmodule

// File: sv/fpre_coder.sv
// Residual sum, zigzag map and Rice / escape code generation.
module fpre_coder #(
    parameter int MAX_TAPS = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fpre_pkg::cfg_t                    cfg,
    input  logic                              load,
    input  logic                              in_valid,
    input  logic [fpre_pkg::SAMPLE_BITS-1:0]  in_prod [MAX_TAPS],
    input  logic                              in_last,
    output logic                              out_valid,
    output fpre_pkg::code_t                   out_code
);
    logic [fpre_pkg::SAMPLE_BITS-1:0] res;
    logic [fpre_pkg::SAMPLE_BITS-1:0] mapped;
    logic [fpre_pkg::SAMPLE_BITS-1:0] quo;
    logic [4:0]                       k;
    logic                             esc;
    logic [fpre_pkg::CODE_BITS-1:0]   one_k;
    fpre_pkg::code_t                  code_next;
    fpre_pkg::code_t                  code_reg;
    logic                             valid_reg, valid_next;

    always_comb begin
        res = '0;
        for (int j = 0; j < MAX_TAPS; j++) begin
            res = res + in_prod[j];
        end
        mapped = res[fpre_pkg::SAMPLE_BITS-1] ? {~res[fpre_pkg::SAMPLE_BITS-2:0], 1'b1}
                                              : {res[fpre_pkg::SAMPLE_BITS-2:0], 1'b0};
        k   = (int'(cfg.rice_shift) > fpre_pkg::MAX_SHIFT) ? 5'(fpre_pkg::MAX_SHIFT)
                                                           : cfg.rice_shift;
        quo = mapped >> k;
        esc = int'(quo) >= fpre_pkg::ESC_Q;
        one_k = fpre_pkg::CODE_BITS'(1) << k;
        code_next.last = in_last;
        if (esc) begin
            code_next.code = {1'b1, mapped};
            code_next.len  = fpre_pkg::LEN_BITS'(fpre_pkg::ESC_LEN);
        end else begin
            code_next.code = one_k | ({1'b0, mapped} & (one_k - fpre_pkg::CODE_BITS'(1)));
            code_next.len  = fpre_pkg::LEN_BITS'(quo[2:0]) + fpre_pkg::LEN_BITS'(1) + k;
        end
        valid_next = load ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && in_valid) begin
            code_reg <= code_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_code  = code_reg;

endmodule

// File: sv/fpre_packer.sv
// Bit packer: appends codes MSB-first, emits full words and the end-of-waveform flush.
module fpre_packer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             take,
    input  fpre_pkg::code_t  in_code,
    output fpre_pkg::push_t  push
);
    localparam int WB = fpre_pkg::WORD_BITS;
    localparam int TB = fpre_pkg::TOTAL_BITS;

    logic [WB-1:0] pend_reg, pend_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [TB-1:0] emit_reg, emit_next;

    logic [2*WB-1:0] bits;
    logic [5:0]      sum;
    logic            full;
    logic [4:0]      rem;
    logic [WB-1:0]   word_a;
    logic [WB-1:0]   keep;
    logic [WB-1:0]   flush;
    logic            need_flush;
    logic [TB-1:0]   e1, e2;

    always_comb begin
        bits = ({{WB{1'b0}}, pend_reg} << in_code.len)
             | (2*WB)'(in_code.code);
        sum  = 6'(cnt_reg) + 6'(in_code.len);
        full = int'(sum) >= WB;
        rem  = full ? 5'(sum - 6'(WB)) : sum[4:0];
        word_a = WB'(bits >> rem);
        keep   = WB'(bits & (((2*WB)'(1) << rem) - (2*WB)'(1)));
        flush  = keep << (6'(WB) - 6'(rem));
        need_flush = in_code.last && (rem != '0);

        e1 = emit_reg;
        if (full && (emit_reg != {TB{1'b1}})) begin
            e1 = emit_reg + TB'(1);
        end
        e2 = e1;
        if (need_flush && (e1 != {TB{1'b1}})) begin
            e2 = e1 + TB'(1);
        end

        push.push0 = 1'b0;
        push.push1 = 1'b0;
        push.res0  = '0;
        push.res1  = '0;
        if (take) begin
            if (full) begin
                push.push0           = 1'b1;
                push.res0.word       = word_a;
                push.res0.final_word = in_code.last && !need_flush;
                push.res0.total      = (in_code.last && !need_flush) ? e1 : '0;
                if (need_flush) begin
                    push.push1           = 1'b1;
                    push.res1.word       = flush;
                    push.res1.final_word = 1'b1;
                    push.res1.total      = e2;
                end
            end else if (need_flush) begin
                push.push0           = 1'b1;
                push.res0.word       = flush;
                push.res0.final_word = 1'b1;
                push.res0.total      = e2;
            end
        end

        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        emit_next = emit_reg;
        if (take) begin
            if (in_code.last) begin
                pend_next = '0;
                cnt_next  = '0;
                emit_next = '0;
            end else begin
                pend_next = keep;
                cnt_next  = rem;
                emit_next = e1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            cnt_reg  <= '0;
            emit_reg <= '0;
        end else begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
            emit_reg <= emit_next;
        end
    end

endmodule

// File: sv/fpre_out_fifo.sv
// Result queue: takes up to two words per cycle, hands out one.
module fpre_out_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fpre_pkg::push_t      push,
    input  logic                 pop,
    output logic                 room,
    output logic                 out_valid,
    output fpre_pkg::result_t    out_res
);
    localparam int DEPTH = fpre_pkg::OUT_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    fpre_pkg::result_t mem [DEPTH];
    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_pop;

    always_comb begin
        do_pop     = pop && (count_reg != '0);
        wr_next    = wr_reg + AW'(push.push0) + AW'(push.push1);
        rd_next    = rd_reg + AW'(do_pop);
        count_next = count_reg + CW'(push.push0) + CW'(push.push1) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.push0) begin
            mem[wr_reg] <= push.res0;
        end
        if (push.push1) begin
            mem[wr_reg + AW'(1)] <= push.res1;
        end
    end

    // two free slots needed, since one item can end in two words
    assign room      = int'(count_reg) <= DEPTH - 2;
    assign out_valid = count_reg != '0;
    assign out_res   = mem[rd_reg];

endmodule

// File: sv/fir_predict_rice_encoder.sv
// Top level of the predictive Rice encoder: config registers, pipeline control, checks.
//
// Input stream s_*: one signed 16-bit sample per item in s_tdata, s_tlast marks the
// last sample of a waveform. Prediction history never crosses a waveform boundary.
// Output stream m_*: one 32-bit code word per item, first code bit in the MSB.
// m_tlast marks the waveform's last word, which also carries the saturating word
// count in m_tdata[47:32] (zero on other words).
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index (0 rice_shift,
// 1 tap_count, 2..5 coefficients); write only while the block is idle.
// Throughput: one sample per cycle when not stalled. A sample ending its waveform
// may produce two words; the 4-entry result queue absorbs them, so the input stalls
// only when the queue holds more than two words.
// A sample's filter products load on the edge that accepts it, then the coder register,
// then the queue write, after which its result item shows on m_*.
// Reset (synchronous, aresetn low) restores the register defaults (k=3, taps 1,-1),
// clears history, pending bits and the queue. When m_tready is low, the queue fills,
// then the pipeline holds and s_tready drops; no item is lost or repeated.
module fir_predict_rice_encoder #(
    parameter int MAX_TAPS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [fpre_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [fpre_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tlast,   // wave_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] code_word, [47:32] word_total
    output logic        m_tlast    // final_word
);
    fpre_pkg::cfg_t  cfg_reg, cfg_next;
    logic            v1, v2, room;
    logic            take2, ld2, ld1, accept;
    logic [fpre_pkg::SAMPLE_BITS-1:0] prod [MAX_TAPS];
    logic            last1;
    fpre_pkg::code_t code2;
    fpre_pkg::push_t push;
    fpre_pkg::result_t res;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                fpre_pkg::REG_RICE_SHIFT: cfg_next.rice_shift = cfg_wdata[4:0];
                fpre_pkg::REG_TAP_COUNT:  cfg_next.tap_count  = cfg_wdata[2:0];
                fpre_pkg::REG_COEF_ZERO:  cfg_next.coef[0]    = cfg_wdata;
                fpre_pkg::REG_COEF_ONE:   cfg_next.coef[1]    = cfg_wdata;
                fpre_pkg::REG_COEF_TWO:   cfg_next.coef[2]    = cfg_wdata;
                fpre_pkg::REG_COEF_THREE: cfg_next.coef[3]    = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rice_shift <= 5'd3;
            cfg_reg.tap_count  <= 3'd2;
            cfg_reg.coef[0]    <= 16'h0001;
            cfg_reg.coef[1]    <= 16'hFFFF;
            cfg_reg.coef[2]    <= 16'h0000;
            cfg_reg.coef[3]    <= 16'h0000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // pipeline moves unless the packer stage is full and the queue lacks room
    assign take2    = v2 && room;
    assign ld2      = !v2 || take2;
    assign ld1      = !v1 || ld2;
    assign s_tready = ld1;
    assign accept   = s_tvalid && ld1;

    fpre_filter #(.MAX_TAPS(MAX_TAPS)) u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .load      (ld1),
        .in_accept (accept),
        .in_sample (s_tdata),
        .in_last   (s_tlast),
        .out_valid (v1),
        .out_prod  (prod),
        .out_last  (last1)
    );

    fpre_coder #(.MAX_TAPS(MAX_TAPS)) u_coder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .load      (ld2),
        .in_valid  (v1),
        .in_prod   (prod),
        .in_last   (last1),
        .out_valid (v2),
        .out_code  (code2)
    );

    fpre_packer u_packer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take2),
        .in_code (code2),
        .push    (push)
    );

    fpre_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_tready),
        .room      (room),
        .out_valid (m_tvalid),
        .out_res   (res)
    );

    assign m_tdata = {res.total, res.word};
    assign m_tlast = res.final_word;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result queue not empty after reset");

    a_final_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[47:32] != 16'd0)
        else $error("final word carries zero word count");

    a_mid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[47:32] == 16'd0)
        else $error("non-final word carries a word count");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> v1 && v2 && !room)
        else $error("input stalled with free pipeline stage");

endmodule

// File: test/fir_predict_rice_encoder_tb.sv
// Self-checking testbench for the predictive Rice encoder: directed and random runs.
`timescale 1ns / 1ps

module fir_predict_rice_encoder_tb;

    localparam int MAX_TAPS    = 4;
    localparam int HIST_DEPTH  = MAX_TAPS - 1;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int REPORT_CAP  = 100;

    typedef enum {SHAPE_WALK, SHAPE_NOISE, SHAPE_RAMP} wave_shape_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    fir_predict_rice_encoder #(.MAX_TAPS(MAX_TAPS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // encoder settings as the block should hold them
    logic [4:0]  shift_reg = 5'd3;
    logic [2:0]  taps_reg  = 3'd2;
    logic [15:0] coef [fpre_pkg::NUM_COEF] = '{16'd1, 16'hFFFF, 16'd0, 16'd0};

    // per-waveform coder state
    logic [15:0] hist [HIST_DEPTH] = '{default: '0};
    logic [31:0] pend_bits = '0;
    int          pend_cnt  = 0;
    int          seen      = 0;
    int          words_out = 0;

    fpre_pkg::result_t words_due [$];

    bit steady = 1'b0;   // when set, neither side idles
    int samples_sent  = 0;
    int waves_sent    = 0;
    int words_checked = 0;
    int mismatches    = 0;
    int cycles        = 0;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge aclk)
        m_tready <= steady || ($urandom_range(0, 99) >= 33);

    function automatic void flag(input string msg);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $error("%s", msg);
    endfunction

    always @(posedge aclk) begin : check_words
        fpre_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (words_due.size() == 0) begin
                flag($sformatf("unexpected code word %h", m_tdata[31:0]));
            end else begin
                want = words_due.pop_front();
                words_checked++;
                if (m_tdata[31:0] !== want.word)
                    flag($sformatf("code_word: expected %h, got %h", want.word, m_tdata[31:0]));
                if (m_tlast !== want.final_word)
                    flag($sformatf("final_word: expected %0d, got %0d", want.final_word, m_tlast));
                if (m_tdata[47:32] !== want.total)
                    flag($sformatf("word_total: expected %0d, got %0d", want.total,
                                   m_tdata[47:32]));
            end
        end
    end

    function automatic void clear_wave();
        hist      = '{default: '0};
        pend_bits = '0;
        pend_cnt  = 0;
        seen      = 0;
        words_out = 0;
    endfunction

    // filter, zigzag, Rice/escape code and pack one sample; queue the words it completes
    function automatic void encode_sample(input logic [15:0] x, input logic endw);
        int ntaps, k, acc, q, len, cnt;
        logic [15:0] res;
        logic [16:0] mapped;
        logic [31:0] code;
        logic [63:0] bits;
        fpre_pkg::result_t r;
        fpre_pkg::result_t outs [$];
        ntaps = (taps_reg == 0) ? 1 : ((taps_reg > MAX_TAPS) ? MAX_TAPS : int'(taps_reg));
        k = (shift_reg > fpre_pkg::MAX_SHIFT) ? fpre_pkg::MAX_SHIFT : int'(shift_reg);
        acc = int'($signed(x)) * int'($signed(coef[0]));
        for (int j = 1; j < ntaps; j++)
            if (j <= seen)
                acc += int'($signed(hist[j - 1])) * int'($signed(coef[j]));
        res = acc[15:0];
        mapped = res[15] ? {~res, 1'b1} : {res, 1'b0};
        q = int'(mapped >> k);
        if (q < fpre_pkg::ESC_Q) begin
            code = (32'd1 << k) | (32'(mapped) & ((32'd1 << k) - 32'd1));
            len  = q + 1 + k;
        end else begin
            code = (32'd1 << fpre_pkg::SAMPLE_BITS) | 32'(mapped);
            len  = fpre_pkg::ESC_LEN;
        end
        bits = ({32'd0, pend_bits} << len) | {32'd0, code};
        cnt  = pend_cnt + len;
        r    = '0;
        if (cnt >= fpre_pkg::WORD_BITS) begin
            cnt -= fpre_pkg::WORD_BITS;
            r.word = 32'(bits >> cnt);
            bits &= (64'd1 << cnt) - 64'd1;
            if (words_out < 65535) words_out++;
            outs.push_back(r);
        end
        if (endw && cnt != 0) begin
            r.word = 32'(bits << (fpre_pkg::WORD_BITS - cnt));
            if (words_out < 65535) words_out++;
            outs.push_back(r);
        end
        if (endw) begin
            // the last word of the waveform carries the count
            r = outs.pop_back();
            r.final_word = 1'b1;
            r.total = 16'(words_out);
            outs.push_back(r);
            clear_wave();
        end else begin
            pend_bits = bits[31:0];
            pend_cnt  = cnt;
            for (int j = HIST_DEPTH - 1; j > 0; j--)
                hist[j] = hist[j - 1];
            hist[0] = x;
            if (seen < HIST_DEPTH) seen++;
        end
        foreach (outs[i]) words_due.push_back(outs[i]);
    endfunction

    // entered and left at a falling edge; valid stays high into the next item
    task automatic push_sample(input logic [15:0] smp, input logic endw);
        if (!steady)
            while ($urandom_range(0, 99) < 33) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= endw;
        do @(posedge aclk); while (!s_tready);
        encode_sample(smp, endw);
        samples_sent++;
        if (endw) waves_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (words_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic put_reg(input fpre_pkg::cfg_index_t idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        case (idx)
            fpre_pkg::REG_RICE_SHIFT: shift_reg = val[4:0];
            fpre_pkg::REG_TAP_COUNT:  taps_reg  = val[2:0];
            fpre_pkg::REG_COEF_ZERO:  coef[0]   = val;
            fpre_pkg::REG_COEF_ONE:   coef[1]   = val;
            fpre_pkg::REG_COEF_TWO:   coef[2]   = val;
            fpre_pkg::REG_COEF_THREE: coef[3]   = val;
            default: ;
        endcase
    endtask

    // only called with the block idle
    task automatic load_settings(input logic [15:0] sh, input logic [15:0] tp,
                                 input logic [15:0] c0, input logic [15:0] c1,
                                 input logic [15:0] c2, input logic [15:0] c3);
        cfg_wr_en <= 1'b1;
        put_reg(fpre_pkg::REG_RICE_SHIFT, sh);
        put_reg(fpre_pkg::REG_TAP_COUNT, tp);
        put_reg(fpre_pkg::REG_COEF_ZERO, c0);
        put_reg(fpre_pkg::REG_COEF_ONE, c1);
        put_reg(fpre_pkg::REG_COEF_TWO, c2);
        put_reg(fpre_pkg::REG_COEF_THREE, c3);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_wave(input int len, input wave_shape_t shape);
        logic [15:0] s;
        int amp, slope;
        s = 16'($urandom);
        amp = 1 << $urandom_range(0, 8);
        slope = int'($urandom_range(0, 2 * amp)) - amp;
        for (int i = 0; i < len; i++) begin
            case (shape)
                SHAPE_WALK:  s = s + 16'(int'($urandom_range(0, 2 * amp)) - amp);
                SHAPE_NOISE: s = 16'($urandom);
                default:     s = s + 16'(slope);
            endcase
            push_sample(s, i == len - 1);
        end
    endtask

    // reset settings: delta filter, k = 3, full-scale swings force escapes
    task automatic test_delta_extremes();
        push_sample(16'h0000, 1'b0);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0001, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'h8000, 1'b1);
        push_sample(16'd12345, 1'b1);
        drain_block();
    endtask

    // eight 4-bit codes fill one word exactly as the waveform ends: no flush word
    task automatic test_word_boundary();
        load_settings(16'd3, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0);
        for (int i = 0; i < 8; i++)
            push_sample(16'h0000, i == 7);
        drain_block();
    endtask

    task automatic test_special_settings();
        // shift above 16 clamps, tap count above four clamps, extreme coefficients
        load_settings(16'd31, 16'd7, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b1);
        drain_block();
        // tap count zero acts as one tap: sample times coef_zero
        load_settings(16'd17, 16'd0, 16'h8000, 16'h1234, 16'h5678, 16'h9ABC);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h0001, 1'b0);
        push_sample(16'hFFFF, 1'b1);
        drain_block();
        // k = 0 with a tap count of five
        load_settings(16'd0, 16'd5, 16'd1, 16'hFFFF, 16'd0, 16'd0);
        push_sample(16'h0003, 1'b0);
        push_sample(16'hFFFD, 1'b1);
        drain_block();
    endtask

    task automatic test_random_streams();
        int goal, phase, nwaves, len;
        logic [15:0] sh, tp;
        logic [15:0] c [fpre_pkg::NUM_COEF];
        goal  = samples_sent + RANDOM_ITEMS;
        phase = 0;
        while (samples_sent < goal) begin
            steady = (phase >= 6 && phase < 12);
            sh = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(17, 31))
                                             : 16'($urandom_range(0, 16));
            tp = 16'($urandom_range(0, 7));
            case ($urandom_range(0, 5))
                0: c = '{16'd1, 16'hFFFF, 16'd0, 16'd0};
                1: c = '{16'd1, 16'hFFFE, 16'd1, 16'd0};
                2: c = '{16'd1, 16'hFFFD, 16'd3, 16'hFFFF};
                3: c = '{16'd1, 16'd0, 16'd0, 16'd0};
                default: c = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
            endcase
            if ($urandom_range(0, 9) == 0) sh = {11'($urandom), 5'd3};   // upper bits ignored
            load_settings(sh, tp, c[0], c[1], c[2], c[3]);
            nwaves = $urandom_range(1, 4);
            for (int w = 0; w < nwaves; w++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                  : $urandom_range(1, 40);
                case ($urandom_range(0, 9))
                    0, 1:    send_wave(len, SHAPE_NOISE);
                    2, 3:    send_wave(len, SHAPE_RAMP);
                    default: send_wave(len, SHAPE_WALK);
                endcase
            end
            drain_block();
            phase++;
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_delta_extremes();
        test_word_boundary();
        test_special_settings();
        test_random_streams();
        $display("Encoded %0d samples in %0d waveforms; %0d code words compared.",
                 samples_sent, waves_sent, words_checked);
        $display("Covered reset taps, shifts 0..31, tap counts 0..7, escapes and word ends.");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
sv/fpre_pkg.sv
sv/fpre_filter.sv
sv/fpre_coder.sv
sv/fpre_packer.sv
sv/fpre_out_fifo.sv
sv/fir_predict_rice_encoder.sv
test/fir_predict_rice_encoder_tb.sv
